// ===== hw/rtl/point_cloud_elevation_grid_core_defines.svh =====
// Assertion helpers for the elevation grid core.
`ifndef POINT_CLOUD_ELEVATION_GRID_CORE_DEFINES_SVH
`define POINT_CLOUD_ELEVATION_GRID_CORE_DEFINES_SVH

// same-cycle implication
`define PCEG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCEG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pceg_pkg.sv =====
`timescale 1ns / 1ps
package pceg_pkg;

    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = 60;
    localparam int ACC_W   = 61;
    localparam int ADDR_W  = 5;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] REG_MIN_RANGE = 3'd0;
    localparam logic [2:0] REG_MAX_RANGE = 3'd1;
    localparam logic [2:0] REG_H_OFFSET  = 3'd2;
    localparam logic [2:0] REG_H_FLOOR   = 3'd3;
    localparam logic [2:0] REG_H_CEIL    = 3'd4;
    localparam logic [2:0] REG_CELL_SIZE = 3'd5;
    localparam logic [2:0] REG_ROBOT     = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] x_value;
        logic signed [23:0] y_value;
        logic signed [23:0] z_value;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
    } item_t;

    typedef struct packed {
        logic               cell_valid;
        logic signed [23:0] cell_height_mm;
        logic [7:0]         updater_id;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic [7:0]         updater;
        logic signed [23:0] height;
    } cell_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MAT,
        ST_RANGE,
        ST_ROT,
        ST_BIN,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_RDOUT
    } state_t;

endpackage

// ===== hw/rtl/pceg_mem.sv =====
`timescale 1ns / 1ps
module pceg_mem
    import pceg_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output cell_t         rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  cell_t         wr_data
);

    cell_t mem [DEPTH];
    cell_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pceg_mul.sv =====
`timescale 1ns / 1ps
module pceg_mul
    import pceg_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/pceg_div.sv =====
`timescale 1ns / 1ps
module pceg_div
    import pceg_pkg::*;
#(
    parameter int QW = 6,
    parameter int DW = 23
) (
    input  logic          clk,
    input  logic          load,
    input  logic          step,
    input  logic [DW-1:0] num_a,
    input  logic [DW-1:0] num_b,
    input  logic [16:0]   den,
    output logic [QW-1:0] q_a,
    output logic [QW-1:0] q_b
);

    // restoring division, one quotient bit per step, two lanes share the divisor
    logic [DW-1:0] rem_a_reg, rem_b_reg, dsh_reg;
    logic [QW-1:0] q_a_reg, q_b_reg;
    logic          ge_a, ge_b;

    assign ge_a = rem_a_reg >= dsh_reg;
    assign ge_b = rem_b_reg >= dsh_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_a_reg <= num_a;
            rem_b_reg <= num_b;
            dsh_reg   <= DW'(den) << (QW - 1);
            q_a_reg   <= '0;
            q_b_reg   <= '0;
        end
        else if (step)
        begin
            rem_a_reg <= ge_a ? rem_a_reg - dsh_reg : rem_a_reg;
            rem_b_reg <= ge_b ? rem_b_reg - dsh_reg : rem_b_reg;
            q_a_reg   <= QW'({q_a_reg, ge_a});
            q_b_reg   <= QW'({q_b_reg, ge_b});
            dsh_reg   <= dsh_reg >> 1;
        end
    end

    assign q_a = q_a_reg;
    assign q_b = q_b_reg;

endmodule

// ===== hw/rtl/point_cloud_elevation_grid_core.sv =====
`timescale 1ns / 1ps
// Elevation grid core: bins range points into a max-height cell grid.
// Item channel: a beat on item is taken at a clock edge with start high and
// busy low. kind selects frame (pose load + grid clear), point, or cell read.
// Result channel: a read item gives one result beat on result, marked by done
// for exactly one cycle; it appears in the cycle after the accepting edge.
// The receiver cannot stall, so the core never waits on the result side.
// Item steps with busy high, in the sequencer that shares one
// 35x25 multiplier and in the cell memory (read, then write back):
//   read item    the result step (RDOUT)
//   point item   range test, which may drop it; otherwise rotation,
//                binning, division, cell read and write-back;
//                a point outside the grid ends after binning
//   frame item   a clearing sweep of one cell a cycle, then the rotation
//                matrix is formed
// Items run one at a time; busy is high through the whole item, and the next
// beat is taken at the end of the first cycle with busy low.
// Reset runs the same sweep with busy high.
// Configuration is an APB-style port, taken at any time; write it only while
// busy is low.
module point_cloud_elevation_grid_core
    import pceg_pkg::*;
#(
    parameter int GRID_CELLS_X = 64,
    parameter int GRID_CELLS_Y = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

`include "point_cloud_elevation_grid_core_defines.svh"

    localparam int CELLS = GRID_CELLS_X * GRID_CELLS_Y;
    localparam int IDX_W = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_CELLS_X);
    localparam int CW    = $clog2(GRID_CELLS_Y);
    localparam int QW    = (RW > CW) ? RW : CW;
    localparam int DW    = QW + 17;
    localparam int CNT_W = (IDX_W > 4) ? IDX_W : 4;

    localparam logic signed [MUL_A_W-1:0] ONE_Q30 = MUL_A_W'(64'sd1 << 30);
    localparam logic signed [ACC_W-1:0]   HALF_Q30 = ACC_W'(64'sd1 << 29);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0] cnt4;

    // configuration registers
    logic [15:0]        min_reg, max_reg, cellsz_reg;
    logic signed [23:0] offs_reg, floor_reg, ceil_reg;
    logic [7:0]         robot_reg;
    logic [31:0]        lo_reg, hi_reg;

    // pose
    logic signed [23:0] pose_x_reg, pose_y_reg, pose_z_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic               pose_loaded_reg;
    logic signed [31:0] pq_reg [9];
    logic signed [MUL_A_W-1:0] m_reg [9];

    // point datapath
    logic signed [23:0]      px_reg, py_reg, pz_reg;
    logic [47:0]             r2_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [23:0]      h_reg;
    logic                    rd_in_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic [47:0] r2_sum;
    logic        keep;
    logic [3:0]  prev4;
    logic [1:0]  acc_sel;

    logic signed [30:0] rx, ry, rz;
    logic [15:0]        cell_eff;
    logic signed [39:0] cell_s, span_x, span_y, nx, ny;
    logic               in_grid;
    logic signed [32:0] hsum, hflr, hclp;

    logic [QW-1:0]    q_a, q_b;
    logic [IDX_W-1:0] pt_idx, rd_idx;
    logic             rd_ok;

    logic             mem_rd_en, mem_wr_en;
    logic [IDX_W-1:0] mem_rd_addr, mem_wr_addr;
    cell_t            mem_rd_data, mem_wr_data;

    logic accept, cfg_wr;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cnt4   = cnt_reg[3:0];
    assign prev4  = cnt4 - 4'd1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= 16'd0;
            max_reg    <= 16'hFFFF;
            offs_reg   <= 24'sd0;
            floor_reg  <= 24'sh800000;
            ceil_reg   <= 24'sh7FFFFF;
            cellsz_reg <= 16'd100;
            robot_reg  <= 8'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_MIN_RANGE: min_reg    <= pwdata[15:0];
                REG_MAX_RANGE: max_reg    <= pwdata[15:0];
                REG_H_OFFSET:  offs_reg   <= pwdata[23:0];
                REG_H_FLOOR:   floor_reg  <= pwdata[23:0];
                REG_H_CEIL:    ceil_reg   <= pwdata[23:0];
                REG_CELL_SIZE: cellsz_reg <= pwdata[15:0];
                REG_ROBOT:     robot_reg  <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MIN_RANGE: prdata = 32'(min_reg);
            REG_MAX_RANGE: prdata = 32'(max_reg);
            REG_H_OFFSET:  prdata = {8'd0, offs_reg};
            REG_H_FLOOR:   prdata = {8'd0, floor_reg};
            REG_H_CEIL:    prdata = {8'd0, ceil_reg};
            REG_CELL_SIZE: prdata = 32'(cellsz_reg);
            REG_ROBOT:     prdata = 32'(robot_reg);
            default:       prdata = 32'd0;
        endcase
    end

    // squared range limits, registered from min_reg and max_reg
    always_ff @(posedge clk)
    begin
        lo_reg <= 32'(min_reg) * 32'(min_reg);
        hi_reg <= 32'(max_reg) * 32'(max_reg);
    end

    // ----------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (item.kind)
                        KIND_FRAME: state_next = ST_CLEAR;
                        KIND_POINT: state_next = ST_RANGE;
                        KIND_READ:  state_next = ST_RDOUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: if (cnt_reg == CNT_W'(CELLS - 1)) state_next = ST_MAT;
            ST_MAT:   if (cnt_reg == CNT_W'(10)) state_next = ST_IDLE;
            ST_RANGE:
            begin
                if (cnt_reg == CNT_W'(2))
                begin
                    state_next = keep ? ST_ROT : ST_IDLE;
                end
            end
            ST_ROT:   if (cnt_reg == CNT_W'(9)) state_next = ST_BIN;
            ST_BIN:   state_next = in_grid ? ST_DIV : ST_IDLE;
            ST_DIV:   if (cnt_reg == CNT_W'(QW - 1)) state_next = ST_RD;
            ST_RD:    state_next = ST_WR;
            ST_WR:    state_next = ST_IDLE;
            ST_RDOUT: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // pose, loaded by a frame beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg      <= '0;
            pose_y_reg      <= '0;
            pose_z_reg      <= '0;
            qw_reg          <= 16'sd32767;
            qx_reg          <= '0;
            qy_reg          <= '0;
            qz_reg          <= '0;
            pose_loaded_reg <= 1'b0;
        end
        else if (accept && item.kind == KIND_FRAME)
        begin
            pose_x_reg      <= item.x_value;
            pose_y_reg      <= item.y_value;
            pose_z_reg      <= item.z_value;
            qw_reg          <= item.quat_w;
            qx_reg          <= item.quat_x;
            qy_reg          <= item.quat_y;
            qz_reg          <= item.quat_z;
            pose_loaded_reg <= 1'b1;
        end
    end

    // --------------------------------------------------- shared multiplier
    // MAT: nine quaternion products; RANGE: x^2, y^2; ROT: R*p, row by row.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MAT:
            begin
                unique case (cnt4)
                    4'd0: begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(qx_reg); end
                    4'd1: begin mul_a = MUL_A_W'(qy_reg); mul_b = MUL_B_W'(qy_reg); end
                    4'd2: begin mul_a = MUL_A_W'(qz_reg); mul_b = MUL_B_W'(qz_reg); end
                    4'd3: begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(qy_reg); end
                    4'd4: begin mul_a = MUL_A_W'(qw_reg); mul_b = MUL_B_W'(qz_reg); end
                    4'd5: begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(qz_reg); end
                    4'd6: begin mul_a = MUL_A_W'(qw_reg); mul_b = MUL_B_W'(qy_reg); end
                    4'd7: begin mul_a = MUL_A_W'(qy_reg); mul_b = MUL_B_W'(qz_reg); end
                    4'd8: begin mul_a = MUL_A_W'(qw_reg); mul_b = MUL_B_W'(qx_reg); end
                    default: ;
                endcase
            end
            ST_RANGE:
            begin
                if (cnt4 == 4'd0)
                begin
                    mul_a = MUL_A_W'(px_reg);
                    mul_b = MUL_B_W'(px_reg);
                end
                else
                begin
                    mul_a = MUL_A_W'(py_reg);
                    mul_b = MUL_B_W'(py_reg);
                end
            end
            ST_ROT:
            begin
                if (cnt4 < 4'd9)
                begin
                    mul_a = m_reg[cnt4];
                end
                unique case (cnt4)
                    4'd0, 4'd3, 4'd6: mul_b = MUL_B_W'(px_reg);
                    4'd1, 4'd4, 4'd7: mul_b = MUL_B_W'(py_reg);
                    4'd2, 4'd5, 4'd8: mul_b = MUL_B_W'(pz_reg);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    pceg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // product lands in the cycle after issue; pick its accumulator
    always_comb
    begin
        unique case (prev4)
            4'd0, 4'd1, 4'd2: acc_sel = 2'd0;
            4'd3, 4'd4, 4'd5: acc_sel = 2'd1;
            default:          acc_sel = 2'd2;
        endcase
    end

    assign r2_sum = r2_reg + prod[47:0];
    assign keep   = pose_loaded_reg && (r2_sum >= 48'(lo_reg)) && (r2_sum <= 48'(hi_reg));

    // ------------------------------------------------------------ binning
    assign rx       = acc_reg[0][ACC_W-1:30];
    assign ry       = acc_reg[1][ACC_W-1:30];
    assign rz       = acc_reg[2][ACC_W-1:30];
    assign cell_eff = (cellsz_reg == 16'd0) ? 16'd1 : cellsz_reg;
    assign cell_s   = $signed(40'(cell_eff));
    assign span_x   = cell_s * 40'(GRID_CELLS_X);
    assign span_y   = cell_s * 40'(GRID_CELLS_Y);
    assign nx       = span_x - (40'(rx) <<< 1);
    assign ny       = span_y - (40'(ry) <<< 1);
    assign in_grid  = (nx >= 0) && (nx < (span_x <<< 1)) &&
                      (ny >= 0) && (ny < (span_y <<< 1));

    assign hsum = 33'(rz) + 33'(pose_z_reg) + 33'(offs_reg);
    assign hflr = (hsum < 33'(floor_reg)) ? 33'(floor_reg) : hsum;
    assign hclp = (hflr > 33'(ceil_reg)) ? 33'(ceil_reg) : hflr;

    pceg_div #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .load  (state_reg == ST_BIN),
        .step  (state_reg == ST_DIV),
        .num_a (nx[DW-1:0]),
        .num_b (ny[DW-1:0]),
        .den   ({cell_eff, 1'b0}),
        .q_a   (q_a),
        .q_b   (q_b)
    );

    assign pt_idx = IDX_W'(IDX_W'(q_a[RW-1:0]) * IDX_W'(GRID_CELLS_Y)) + IDX_W'(q_b[CW-1:0]);
    assign rd_ok  = (11'(item.cell_row) < 11'(GRID_CELLS_X)) &&
                    (11'(item.cell_col) < 11'(GRID_CELLS_Y));
    assign rd_idx = IDX_W'(IDX_W'(item.cell_row) * IDX_W'(GRID_CELLS_Y)) +
                    IDX_W'(item.cell_col);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && item.kind == KIND_POINT)
        begin
            px_reg <= item.x_value;
            py_reg <= item.y_value;
            pz_reg <= item.z_value;
        end
        if (accept && item.kind == KIND_READ)
        begin
            rd_in_reg <= rd_ok;
        end
        if (state_reg == ST_MAT && cnt4 >= 4'd1 && cnt4 <= 4'd9)
        begin
            pq_reg[prev4] <= prod[31:0];
        end
        if (state_reg == ST_MAT && cnt4 == 4'd10)
        begin
            // xx yy zz xy wz xz wy yz wx
            m_reg[0] <= ONE_Q30 - ((MUL_A_W'(pq_reg[1]) + MUL_A_W'(pq_reg[2])) <<< 1);
            m_reg[1] <= (MUL_A_W'(pq_reg[3]) - MUL_A_W'(pq_reg[4])) <<< 1;
            m_reg[2] <= (MUL_A_W'(pq_reg[5]) + MUL_A_W'(pq_reg[6])) <<< 1;
            m_reg[3] <= (MUL_A_W'(pq_reg[3]) + MUL_A_W'(pq_reg[4])) <<< 1;
            m_reg[4] <= ONE_Q30 - ((MUL_A_W'(pq_reg[0]) + MUL_A_W'(pq_reg[2])) <<< 1);
            m_reg[5] <= (MUL_A_W'(pq_reg[7]) - MUL_A_W'(pq_reg[8])) <<< 1;
            m_reg[6] <= (MUL_A_W'(pq_reg[5]) - MUL_A_W'(pq_reg[6])) <<< 1;
            m_reg[7] <= (MUL_A_W'(pq_reg[7]) + MUL_A_W'(pq_reg[8])) <<< 1;
            m_reg[8] <= ONE_Q30 - ((MUL_A_W'(pq_reg[0]) + MUL_A_W'(pq_reg[1])) <<< 1);
        end
        if (state_reg == ST_RANGE && cnt4 == 4'd1)
        begin
            r2_reg <= prod[47:0];
        end
        if (state_reg == ST_RANGE)
        begin
            // round-half-up bias preloaded
            acc_reg[0] <= HALF_Q30;
            acc_reg[1] <= HALF_Q30;
            acc_reg[2] <= HALF_Q30;
        end
        if (state_reg == ST_ROT && cnt4 >= 4'd1)
        begin
            acc_reg[acc_sel] <= acc_reg[acc_sel] + ACC_W'(prod);
        end
        if (state_reg == ST_BIN)
        begin
            h_reg <= hclp[23:0];
        end
    end

    // --------------------------------------------------------- cell memory
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = pt_idx;
        mem_wr_en   = 1'b0;
        mem_wr_addr = pt_idx;
        mem_wr_data = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_rd_en   = accept && item.kind == KIND_READ;
                mem_rd_addr = rd_idx;
            end
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg[IDX_W-1:0];
            end
            ST_RD:
            begin
                mem_rd_en = 1'b1;
            end
            ST_WR:
            begin
                // first fill takes robot id; later points only raise height
                if (!mem_rd_data.valid)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = '{valid: 1'b1, updater: robot_reg, height: h_reg};
                end
                else if (h_reg > mem_rd_data.height)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = '{valid: 1'b1, updater: mem_rd_data.updater,
                                    height: h_reg};
                end
            end
            default: ;
        endcase
    end

    pceg_mem #(
        .DEPTH (CELLS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // ------------------------------------------------------------- outputs
    always_comb
    begin
        busy   = state_reg != ST_IDLE;
        done   = state_reg == ST_RDOUT;
        result = '0;
        if (rd_in_reg && mem_rd_data.valid)
        begin
            result.cell_valid     = 1'b1;
            result.cell_height_mm = mem_rd_data.height;
            result.updater_id     = mem_rd_data.updater;
        end
    end

    // ----------------------------------------------------------- assertions
    `PCEG_ASSERT_NXT(a_read_beat, accept && item.kind == KIND_READ, done,
                     "read beat did not yield a result in the next cycle")
    `PCEG_ASSERT_NXT(a_done_single, done, !done && !busy,
                     "result strobe longer than one cycle")
    `PCEG_ASSERT_NXT(a_frame_clear, accept && item.kind == KIND_FRAME,
                     state_reg == ST_CLEAR && pose_loaded_reg,
                     "frame beat did not start the clearing sweep")
    `PCEG_ASSERT_IMP(a_wr_after_rd, state_reg == ST_WR, $past(state_reg) == ST_RD,
                     "cell write-back without a preceding read")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import pceg_pkg::*;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    // a frame sweeps the whole grid; reset does the same
    localparam int STALL_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    item_t       item = '0;
    logic        done;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    point_cloud_elevation_grid_core #(.GRID_CELLS_X(GRID_X), .GRID_CELLS_Y(GRID_Y)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: own copy of the registers, pose and grid
    // ---------------------------------------------------------------
    logic [15:0]        min_range, max_range, cell_size;
    logic signed [23:0] h_offset, h_floor, h_ceil;
    logic [7:0]         robot_id;
    logic signed [23:0] grid_height [GRID_X*GRID_Y];
    logic [7:0]         grid_owner [GRID_X*GRID_Y];
    logic               grid_filled [GRID_X*GRID_Y];
    logic signed [63:0] pose_pos [3];
    logic signed [63:0] pose_q [4];
    logic               have_pose;

    result_t     cell_reads_due [$];
    int          fail_count = 0;
    int          idle_pct = 19;
    int          stall_count = 0;
    int          reads_seen = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
        return (v + 64'sd536870912) >>> 30;   // arithmetic shift floors
    endfunction

    function automatic int to_bin(input logic signed [63:0] r, input int cells,
                                  input logic signed [63:0] csz);
        logic signed [63:0] n;
        n = cells * csz - 2 * r;
        if (n < 0 || n >= 2 * cells * csz)
            return -1;
        return int'(n / (2 * csz));
    endfunction

    task automatic bin_point(input item_t it);
        logic signed [63:0] px, py, pz, w, x, y, z, one, rx, ry, rz, hgt, csz;
        logic signed [63:0] m [9];
        logic [63:0] r2, lo, hi;
        int row, col, idx;
        px = it.x_value; py = it.y_value; pz = it.z_value;
        r2 = px * px + py * py;
        lo = min_range * min_range;
        hi = max_range * max_range;
        if (!have_pose || r2 < lo || r2 > hi)
            return;
        w = pose_q[0]; x = pose_q[1]; y = pose_q[2]; z = pose_q[3];
        one = 64'sd1 << 30;
        m[0] = one - 2 * (y * y + z * z);
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = one - 2 * (x * x + z * z);
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = one - 2 * (x * x + y * y);
        rx = round_q30(m[0] * px + m[1] * py + m[2] * pz);
        ry = round_q30(m[3] * px + m[4] * py + m[5] * pz);
        rz = round_q30(m[6] * px + m[7] * py + m[8] * pz);
        hgt = rz + pose_pos[2] + h_offset;
        if (hgt < h_floor) hgt = h_floor;   // floor first, ceiling wins
        if (hgt > h_ceil) hgt = h_ceil;
        csz = (cell_size == 0) ? 64'sd1 : 64'(cell_size);
        row = to_bin(rx, GRID_X, csz);
        col = to_bin(ry, GRID_Y, csz);
        if (row < 0 || col < 0)
            return;
        idx = row * GRID_Y + col;
        if (grid_filled[idx]) begin
            if (hgt > grid_height[idx])
                grid_height[idx] = hgt[23:0];
        end else begin
            grid_filled[idx] = 1'b1;
            grid_height[idx] = hgt[23:0];
            grid_owner[idx] = robot_id;
        end
    endtask

    task automatic predict_item(input item_t it);
        result_t r;
        int idx;
        case (it.kind)
            KIND_FRAME: begin
                foreach (grid_filled[i]) grid_filled[i] = 1'b0;
                pose_pos[0] = it.x_value; pose_pos[1] = it.y_value;
                pose_pos[2] = it.z_value;
                pose_q[0] = it.quat_w; pose_q[1] = it.quat_x;
                pose_q[2] = it.quat_y; pose_q[3] = it.quat_z;
                have_pose = 1'b1;
            end
            KIND_POINT: bin_point(it);
            KIND_READ: begin
                r = '0;
                idx = it.cell_row * GRID_Y + it.cell_col;
                if (it.cell_row < GRID_X && it.cell_col < GRID_Y && grid_filled[idx]) begin
                    r.cell_valid = 1'b1;
                    r.cell_height_mm = grid_height[idx];
                    r.updater_id = grid_owner[idx];
                end
                cell_reads_due = {cell_reads_due, r};
            end
            default: ;   // unused kind: no effect
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // Result checker: the receiver can't stall, so sample every done
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        if (rst_n && done) begin
            if (cell_reads_due.size() == 0) begin
                report_mismatch("unexpected beat", 32'(result.cell_height_mm), 32'd0);
            end else begin
                want = cell_reads_due.pop_front();
                reads_seen++;
                if (result.cell_valid !== want.cell_valid)
                    report_mismatch("cell_valid", 32'(result.cell_valid),
                                    32'(want.cell_valid));
                if (result.cell_height_mm !== want.cell_height_mm)
                    report_mismatch("cell_height_mm", 32'(result.cell_height_mm),
                                    32'(want.cell_height_mm));
                if (result.updater_id !== want.updater_id)
                    report_mismatch("updater_id", 32'(result.updater_id),
                                    32'(want.updater_id));
            end
        end
    end

    // Watchdog: cycles with nothing accepted
    always @(posedge clk) begin
        if ((start && !busy) || done || (psel && penable))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // start stays high after a beat until the next call or a drain lowers it
    task automatic send_beat(input item_t it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (cell_reads_due.size() != 0)
            @(posedge clk);
        // a point beat may still be binning; let it finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MIN_RANGE: min_range = val[15:0];
            REG_MAX_RANGE: max_range = val[15:0];
            REG_H_OFFSET:  h_offset = val[23:0];
            REG_H_FLOOR:   h_floor = val[23:0];
            REG_H_CEIL:    h_ceil = val[23:0];
            REG_CELL_SIZE: cell_size = val[15:0];
            REG_ROBOT:     robot_id = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input int mn, input int mx, input int off, input int fl,
                           input int ce, input int cs, input int rb);
        wait_drained();
        write_reg(REG_MIN_RANGE, mn); write_reg(REG_MAX_RANGE, mx);
        write_reg(REG_H_OFFSET, off); write_reg(REG_H_FLOOR, fl);
        write_reg(REG_H_CEIL, ce); write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_ROBOT, rb);
    endtask

    // Item builders
    function automatic item_t frame_beat(input int x, input int y, input int z,
                                         input int qw, input int qx, input int qy,
                                         input int qz);
        item_t it;
        it = '0;
        it.kind = KIND_FRAME;
        it.x_value = 24'(x); it.y_value = 24'(y); it.z_value = 24'(z);
        it.quat_w = 16'(qw); it.quat_x = 16'(qx); it.quat_y = 16'(qy); it.quat_z = 16'(qz);
        return it;
    endfunction

    function automatic item_t point_beat(input int x, input int y, input int z);
        item_t it;
        it = '0;
        it.kind = KIND_POINT;
        it.x_value = 24'(x); it.y_value = 24'(y); it.z_value = 24'(z);
        return it;
    endfunction

    function automatic item_t read_beat(input int row, input int col);
        item_t it;
        it = '0;
        it.kind = KIND_READ;
        it.cell_row = 6'(row); it.cell_col = 6'(col);
        return it;
    endfunction

    // random unit-ish quaternion: mostly near identity or a yaw, sometimes wild
    function automatic item_t rand_frame();
        item_t it;
        int sel;
        it = '0;
        it.kind = KIND_FRAME;
        it.x_value = 24'($signed($urandom_range(8000)) - 4000);
        it.y_value = 24'($signed($urandom_range(8000)) - 4000);
        it.z_value = 24'($signed($urandom_range(4000)) - 2000);
        sel = $urandom_range(9);
        if (sel < 4) begin
            it.quat_w = 16'sd32767;
        end else if (sel < 7) begin
            it.quat_w = 16'sd23170; it.quat_z = ($urandom_range(1)) ? 16'sd23170 : -16'sd23170;
        end else begin
            it.x_value = 24'($urandom); it.y_value = 24'($urandom);
            it.z_value = 24'($urandom);
            it.quat_w = 16'($urandom); it.quat_x = 16'($urandom);
            it.quat_y = 16'($urandom); it.quat_z = 16'($urandom);
        end
        return it;
    endfunction

    // random content beats; raw noise in bits and the unused kind too
    function automatic item_t rand_beat(input int cs);
        item_t it;
        int sel, span;
        it = '0;
        it.x_value = 24'($urandom); it.y_value = 24'($urandom);
        it.z_value = 24'($urandom);
        it.quat_w = 16'($urandom); it.quat_x = 16'($urandom);
        it.quat_y = 16'($urandom); it.quat_z = 16'($urandom);
        it.cell_row = 6'($urandom); it.cell_col = 6'($urandom);
        sel = $urandom_range(99);
        span = cs * 32;
        if (sel < 55) begin
            it.kind = KIND_POINT;
            it.x_value = 24'($signed($urandom_range(2 * span)) - span);
            it.y_value = 24'($signed($urandom_range(2 * span)) - span);
            it.z_value = 24'($signed($urandom_range(6000)) - 3000);
        end else if (sel < 60) begin
            it.kind = KIND_POINT;
        end else if (sel < 92) begin
            it.kind = KIND_READ;
        end else if (sel < 95) begin
            it.kind = 2'd3;
        end else begin
            it = rand_frame();
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_values();
        // points before any pose are ignored; reads of empty cells
        send_beat(point_beat(0, 0, 500));
        send_beat(read_beat(32, 32));
        send_beat(read_beat(63, 63));
        send_beat(read_beat(0, 0));
    endtask

    task automatic test_directed();
        set_all(0, 65535, 0, -8388608, 8388607, 100, 8'hA5);
        send_beat(frame_beat(0, 0, 0, 32767, 0, 0, 0));
        send_beat(point_beat(0, 0, 100));
        send_beat(point_beat(0, 0, 300));        // higher wins
        send_beat(point_beat(20, -20, 50));      // next cell over (row 31), lower
        send_beat(point_beat(3199, -3200, 10));  // on the column edge, just outside
        send_beat(point_beat(-3201, 3199, 10));  // just outside
        send_beat(point_beat(8388607, -8388608, 8388607)); // field extremes
        send_beat(point_beat(-8388608, 8388607, -8388608));
        send_beat(read_beat(31, 32));
        send_beat(read_beat(32, 32));
        send_beat(read_beat(0, 0));
        send_beat(read_beat(63, 63));
        // yaw pose with an offset position; extreme quaternion values
        send_beat(frame_beat(-8388608, 8388607, -8388608, -32768, -32768, 32767, -32768));
        send_beat(point_beat(1, 2, 3));
        send_beat(frame_beat(500, -700, 100, 23170, 0, 0, 23170));
        send_beat(point_beat(1000, 0, 0));
        send_beat(point_beat(0, 1000, 0));
        send_beat(read_beat(32, 22));
        send_beat(read_beat(22, 32));
        // floor above ceiling, zero cell size, narrow range window
        set_all(10, 20, -8388608, 1000, -1000, 0, 8'hFF);
        send_beat(frame_beat(0, 0, 0, 32767, 0, 0, 0));
        send_beat(point_beat(12, 0, 7));
        send_beat(point_beat(5, 0, 7));          // below min range
        send_beat(point_beat(30, 0, 7));         // above max range
        send_beat(read_beat(26, 32));
        send_beat(item_t'({2'd3, 148'h0}));
    endtask

    task automatic test_random(input int count);
        int cs;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_all(0, 65535, 0, -8388608, 8388607, 100, 1);
                1: set_all(200, 4000, 8388607, -2000, 2000, 1, 0);
                2: set_all(65535, 65535, -500, 8388607, 8388607, 65535, 255);
                default: set_all($urandom_range(500), $urandom_range(65535, 3000),
                                 $signed($urandom_range(2000)) - 1000, -1500, 1500,
                                 $urandom_range(200, 20), $urandom_range(255));
            endcase
            cs = (cell_size == 0) ? 1 : int'(cell_size);
            if (cs > 400) cs = 400;
            idle_pct = (ph == 1) ? 0 : 19;   // one long stretch with no gaps
            send_beat(rand_frame());
            for (int n = 0; n < count / 4; n++)
                send_beat(rand_beat(cs));
        end
        idle_pct = 19;
    endtask

    initial begin
        min_range = 16'd0; max_range = 16'hFFFF; h_offset = '0;
        h_floor = -24'sd8388608; h_ceil = 24'sd8388607; cell_size = 16'd100;
        robot_id = '0; have_pose = 1'b0;
        pose_pos = '{default: 0}; pose_q = '{64'sd32767, 0, 0, 0};
        foreach (grid_filled[i]) begin
            grid_filled[i] = 1'b0; grid_height[i] = '0; grid_owner[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_random(600);
        wait_drained();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
